>>> hdl/hms_pkg.sv
`timescale 1ns / 1ps

package hms_pkg;

  // element width and default set capacity
  localparam int unsigned DataW    = 32;
  localparam int unsigned MaxItems = 64;

  // input transfer payload
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last_in;
  } hms_in_t;

  // output transfer payload
  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    last_out;
    logic                    overflow;
  } hms_out_t;

  // sequencer to output stage: load the output register with item
  typedef struct packed {
    logic     load;
    hms_out_t item;
  } hms_emit_t;

endpackage

>>> hdl/hms_ram.sv
`timescale 1ns / 1ps

module hms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/hms_seq.sv
`timescale 1ns / 1ps

module hms_seq #(
  parameter int unsigned MAX_ITEMS = hms_pkg::MaxItems,
  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1),
  localparam int unsigned PW = CW + 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  hms_pkg::hms_in_t          in_data_i,
  output logic                      in_stall_o,
  input  logic                      out_free_i,
  output hms_pkg::hms_emit_t        emit_o,
  output logic                      ram_a_we_o,
  output logic                      ram_b_we_o,
  output logic [AW-1:0]             ram_waddr_o,
  output logic [hms_pkg::DataW-1:0] ram_wdata_o,
  output logic                      ram_re_o,
  output logic [AW-1:0]             ram_raddr_o,
  input  logic [hms_pkg::DataW-1:0] ram_a_rdata_i,
  input  logic [hms_pkg::DataW-1:0] ram_b_rdata_i
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_BLK   = 3'd1;
  localparam logic [2:0] S_PRIME = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_EMIT0 = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          drop_q, drop_d;
  logic          sel_q, sel_d;
  logic [CW-1:0] base_q, base_d;
  logic [PW-1:0] width_q, width_d;
  logic [CW-1:0] a_q, a_d, b_q, b_d, mid_q, mid_d, end_q, end_d, k_q, k_d;
  logic          fresh_a_q, fresh_a_d, fresh_b_q, fresh_b_d;
  logic signed [hms_pkg::DataW-1:0] ha_q, ha_d, hb_q, hb_d;

  logic signed [hms_pkg::DataW-1:0] rdata, ha_eff, hb_eff;
  logic [PW-1:0] mid_sum, end_sum, n_ext, width2;
  logic          a_ok, b_ok, take_b;
  logic          wr_dst;

  // read data of the current source buffer
  assign rdata  = sel_q ? ram_b_rdata_i : ram_a_rdata_i;
  assign ha_eff = fresh_a_q ? rdata : ha_q;
  assign hb_eff = fresh_b_q ? rdata : hb_q;

  // block bounds and merge decision
  assign n_ext   = PW'(count_q);
  assign width2  = width_q << 1;
  assign mid_sum = PW'(base_q) + width_q;
  assign end_sum = PW'(base_q) + width2;
  assign a_ok    = a_q < mid_q;
  assign b_ok    = b_q < end_q;
  assign take_b  = b_ok && (!a_ok || (ha_eff > hb_eff));

  assign in_stall_o = (state_q != S_LOAD);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    drop_d    = drop_q;
    sel_d     = sel_q;
    base_d    = base_q;
    width_d   = width_q;
    a_d       = a_q;
    b_d       = b_q;
    mid_d     = mid_q;
    end_d     = end_q;
    k_d       = k_q;
    fresh_a_d = fresh_a_q;
    fresh_b_d = fresh_b_q;
    ha_d      = ha_q;
    hb_d      = hb_q;
    wr_dst      = 1'b0;
    ram_a_we_o  = 1'b0;
    ram_b_we_o  = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    emit_o      = '0;

    unique case (state_q)
      // collect elements into buffer a
      S_LOAD: begin
        if (in_valid_i) begin
          if (count_q < CW'(MAX_ITEMS)) begin
            ram_a_we_o  = 1'b1;
            ram_waddr_o = count_q[AW-1:0];
            ram_wdata_o = in_data_i.value;
            count_d     = count_q + CW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (in_data_i.last_in) begin
            base_d  = '0;
            width_d = PW'(1);
            sel_d   = 1'b0;
            state_d = (count_d > CW'(1)) ? S_BLK : S_EMIT0;
          end
        end
      end

      // set up the pair of runs at base and fetch the head of run a
      S_BLK: begin
        a_d         = base_q;
        k_d         = base_q;
        mid_d       = (mid_sum > n_ext) ? count_q : mid_sum[CW-1:0];
        b_d         = mid_d;
        end_d       = (end_sum > n_ext) ? count_q : end_sum[CW-1:0];
        ram_re_o    = 1'b1;
        ram_raddr_o = base_q[AW-1:0];
        state_d     = S_PRIME;
      end

      // capture head of run a, fetch head of run b
      S_PRIME: begin
        ha_d        = rdata;
        fresh_a_d   = 1'b0;
        fresh_b_d   = 1'b1;
        ram_re_o    = 1'b1;
        ram_raddr_o = b_q[AW-1:0];
        state_d     = S_MERGE;
      end

      // one element to the destination buffer per cycle
      S_MERGE: begin
        wr_dst      = 1'b1;
        ram_waddr_o = k_q[AW-1:0];
        ram_wdata_o = take_b ? hb_eff : ha_eff;
        ha_d        = ha_eff;
        hb_d        = hb_eff;
        ram_re_o    = 1'b1;
        k_d         = k_q + CW'(1);
        if (take_b) begin
          b_d         = b_q + CW'(1);
          ram_raddr_o = b_d[AW-1:0];
          fresh_a_d   = 1'b0;
          fresh_b_d   = 1'b1;
        end else begin
          a_d         = a_q + CW'(1);
          ram_raddr_o = a_d[AW-1:0];
          fresh_a_d   = 1'b1;
          fresh_b_d   = 1'b0;
        end
        if (k_d == end_q) begin
          if (end_sum >= n_ext) begin
            // pass done: swap buffers and double the run length
            sel_d   = ~sel_q;
            width_d = width2;
            base_d  = '0;
            state_d = (width2 >= n_ext) ? S_EMIT0 : S_BLK;
          end else begin
            base_d  = end_sum[CW-1:0];
            state_d = S_BLK;
          end
        end
      end

      // fetch the first sorted element
      S_EMIT0: begin
        k_d         = '0;
        ram_re_o    = 1'b1;
        ram_raddr_o = '0;
        state_d     = S_EMIT;
      end

      // hand elements to the output register while it is free
      S_EMIT: begin
        if (out_free_i) begin
          emit_o.load              = 1'b1;
          emit_o.item.sorted_value = rdata;
          emit_o.item.last_out     = (k_q == count_q - CW'(1));
          emit_o.item.overflow     = drop_q;
          if (k_q == count_q - CW'(1)) begin
            count_d = '0;
            drop_d  = 1'b0;
            state_d = S_LOAD;
          end else begin
            k_d         = k_q + CW'(1);
            ram_re_o    = 1'b1;
            ram_raddr_o = k_d[AW-1:0];
          end
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase

    // destination is the buffer that is not the source
    if (wr_dst) begin
      ram_a_we_o = sel_q;
      ram_b_we_o = ~sel_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_q   <= '0;
      drop_q    <= 1'b0;
      sel_q     <= 1'b0;
      fresh_a_q <= 1'b0;
      fresh_b_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      drop_q    <= drop_d;
      sel_q     <= sel_d;
      fresh_a_q <= fresh_a_d;
      fresh_b_q <= fresh_b_d;
    end
  end

  // pointers and run heads
  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    width_q <= width_d;
    a_q     <= a_d;
    b_q     <= b_d;
    mid_q   <= mid_d;
    end_q   <= end_d;
    k_q     <= k_d;
    ha_q    <= ha_d;
    hb_q    <= hb_d;
  end

  // merge output index tracks both consumed run pointers
  a_merge_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE) |-> (k_q == a_q + b_q - mid_q))
    else $error("merge write index out of step with run pointers");

  a_merge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE) |-> (k_q < end_q && end_q <= count_q))
    else $error("merge write beyond block end");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.load |-> (count_q != '0 && k_q < count_q))
    else $error("emit from an empty or exhausted set");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("element count above capacity");

  a_load_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_a_we_o || ram_b_we_o) |-> (state_q == S_LOAD || state_q == S_MERGE))
    else $error("buffer write outside load or merge");

endmodule

>>> hdl/hybrid_merge_sort.sv
`timescale 1ns / 1ps

// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_stall_o   | in_data_i  (value, last_in)
// out     | output    | out_valid_o / out_stall_i | out_data_o (sorted_value, last_out, overflow)
//
// load: one element per cycle into buffer a; the closing transfer starts the sort
// sort: bottom-up merge between two single-port-read buffers, one element per cycle,
//   in ceil(log2 n) passes, each run pair set up and its two run heads fetched first
// emit: the first result is fetched, then one result per cycle while out_stall_i is low
// reset clears the element count and overflow flag; buffers hold no reset value
// in_stall_o stays high from the closing transfer until the last result is registered

module hybrid_merge_sort #(
  parameter int unsigned MAX_ITEMS = hms_pkg::MaxItems,
  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hms_pkg::hms_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hms_pkg::hms_out_t out_data_o
);

  logic                      ram_a_we, ram_b_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [hms_pkg::DataW-1:0] ram_wdata, ram_a_rdata, ram_b_rdata;
  hms_pkg::hms_emit_t        emit;
  logic                      out_free;
  logic                      out_valid_q;
  hms_pkg::hms_out_t         out_q;

  // ping-pong buffers
  hms_ram #(
    .WIDTH (hms_pkg::DataW),
    .DEPTH (MAX_ITEMS)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ram_a_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_a_rdata)
  );

  hms_ram #(
    .WIDTH (hms_pkg::DataW),
    .DEPTH (MAX_ITEMS)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ram_b_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_b_rdata)
  );

  // load, merge and emit sequencer
  hms_seq #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_data_i     (in_data_i),
    .in_stall_o    (in_stall_o),
    .out_free_i    (out_free),
    .emit_o        (emit),
    .ram_a_we_o    (ram_a_we),
    .ram_b_we_o    (ram_b_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_a_rdata_i (ram_a_rdata),
    .ram_b_rdata_i (ram_b_rdata)
  );

  // output register frees up on the transfer that empties it
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_q <= emit.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a held result is never overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !emit.load)
    else $error("output register loaded while stalled");

  // no element is accepted while results of the set are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.load && !emit.item.last_out) |=> in_stall_o)
    else $error("input open before the set was emitted");

  // write to both buffers at once never happens
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_a_we && ram_b_we))
    else $error("both buffers written in one cycle");

endmodule

>>> tb/hybrid_merge_sort_checker.sv
`timescale 1ns / 1ps

module hybrid_merge_sort_checker #(
  parameter int unsigned CAPACITY = hms_pkg::MaxItems
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  hms_pkg::hms_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  hms_pkg::hms_out_t out_data_i,
  output int                errors_o,
  output int                pending_o
);

  // elements of the set being collected, and sorted results still owed by the block
  logic signed [hms_pkg::DataW-1:0] set_elems_q[$];
  bit                               set_dropped;
  hms_pkg::hms_out_t                sorted_due_q[$];
  int                               err_count = 0;
  int                               pending_count = 0;

  assign errors_o  = err_count;
  assign pending_o = pending_count;

  // order the closed set ascending and queue one result per held element
  function automatic void sort_closed_set();
    logic signed [hms_pkg::DataW-1:0] run[$];
    logic signed [hms_pkg::DataW-1:0] key;
    hms_pkg::hms_out_t                res;
    int                               i;
    int                               j;
    run = set_elems_q;
    for (i = 1; i < run.size(); i++) begin
      key = run[i];
      j = i;
      while (j > 0 && run[j-1] > key) begin
        run[j] = run[j-1];
        j--;
      end
      run[j] = key;
    end
    for (i = 0; i < run.size(); i++) begin
      res.sorted_value = run[i];
      res.last_out     = (i == run.size() - 1);
      res.overflow     = set_dropped;
      sorted_due_q.push_back(res);
    end
    set_elems_q.delete();
    set_dropped = 1'b0;
  endfunction

  // watch both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    hms_pkg::hms_out_t due;
    if (!rst_ni) begin
      set_elems_q.delete();
      sorted_due_q.delete();
      set_dropped = 1'b0;
    end else begin
      // output transfer against the oldest owed result
      if (out_valid_i && !out_stall_i) begin
        if (sorted_due_q.size() == 0) begin
          $display("%0t: unexpected result value %0d last %0b overflow %0b", $time,
                   out_data_i.sorted_value, out_data_i.last_out, out_data_i.overflow);
          err_count++;
        end else begin
          due = sorted_due_q.pop_front();
          if (out_data_i.sorted_value !== due.sorted_value) begin
            $display("%0t: sorted_value expected %0d actual %0d", $time,
                     due.sorted_value, out_data_i.sorted_value);
            err_count++;
          end
          if (out_data_i.last_out !== due.last_out) begin
            $display("%0t: last_out expected %0b actual %0b", $time,
                     due.last_out, out_data_i.last_out);
            err_count++;
          end
          if (out_data_i.overflow !== due.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time,
                     due.overflow, out_data_i.overflow);
            err_count++;
          end
        end
      end
      // input transfer: store or drop, sort on the closing element
      if (in_valid_i && !in_stall_i) begin
        if (set_elems_q.size() < CAPACITY) begin
          set_elems_q.push_back(in_data_i.value);
        end else begin
          set_dropped = 1'b1;
        end
        if (in_data_i.last_in) begin
          sort_closed_set();
        end
      end
    end
    pending_count = sorted_due_q.size();
  end

endmodule

>>> tb/hybrid_merge_sort_tb.sv
`timescale 1ns / 1ps

module hybrid_merge_sort_tb;

  localparam int unsigned Capacity    = hms_pkg::MaxItems;
  localparam int          CycleLimit  = 400000;
  localparam int          HoldCycles  = 2000;
  localparam int          DrainCycles = 100;
  localparam int          RandomItems = 135;
  localparam int          MinSets     = 10;

  localparam logic signed [hms_pkg::DataW-1:0] MinVal = {1'b1, {(hms_pkg::DataW-1){1'b0}}};
  localparam logic signed [hms_pkg::DataW-1:0] MaxVal = {1'b0, {(hms_pkg::DataW-1){1'b1}}};

  // how the values of one set are spread
  typedef enum int {
    SpreadWide,
    SpreadNarrow,
    SpreadEdge
  } spread_e;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  hms_pkg::hms_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  hms_pkg::hms_out_t out_data;

  int errors;
  int pending;
  int cycles;
  int hold_reqs;
  int items_sent;
  bit no_idle;

  logic signed [hms_pkg::DataW-1:0] set_q[$];

  hybrid_merge_sort #(
    .MAX_ITEMS(Capacity)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  hybrid_merge_sort_checker #(
    .CAPACITY(Capacity)
  ) checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("hybrid_merge_sort test failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < 33);
      end
    end
  end

  function automatic logic signed [hms_pkg::DataW-1:0] pick_value(spread_e spread);
    int t;
    case (spread)
      SpreadNarrow: begin
        t = $urandom_range(0, 8);
        return t - 4;
      end
      SpreadEdge: begin
        case ($urandom_range(0, 4))
          0: return MinVal;
          1: return MaxVal;
          2: return '0;
          3: return '1;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // one element; called at a falling edge, returns at the falling edge after its transfer
  task automatic send_elem(input logic signed [hms_pkg::DataW-1:0] v, input bit last);
    int               gap;
    hms_pkg::hms_in_t item;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 33) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.value   = v;
    item.last_in = last;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // send set_q as one set, closing on its final element
  task automatic send_queued_set();
    int i;
    for (i = 0; i < set_q.size(); i++) begin
      send_elem(set_q[i], i == set_q.size() - 1);
    end
    set_q.delete();
  endtask

  // stop offering and wait until every owed result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int      i;
    int      set_idx;
    int      size;
    int      base;
    int      r;
    spread_e spread;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    no_idle    = 1'b0;
    hold_reqs  = 0;
    items_sent = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // single-element sets at both extremes
    set_q.push_back(MinVal);
    send_queued_set();
    set_q.push_back(MaxVal);
    send_queued_set();
    // two elements out of order
    set_q.push_back(5);
    set_q.push_back(-5);
    send_queued_set();
    // extremes, zero, minus one and duplicates
    set_q = '{MaxVal, MinVal, 0, -1, 1, MinVal, MaxVal};
    send_queued_set();
    // twelve elements, strictly descending
    for (i = 0; i < 12; i++) set_q.push_back((6 - i) * 1000);
    send_queued_set();

    // random sets, mostly small
    base = items_sent;
    set_idx = 0;
    while (items_sent - base < RandomItems || set_idx < MinSets) begin
      if (set_idx == 1) begin
        // overflow: a few dropped, the closing element among them
        size = Capacity + $urandom_range(1, 3);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 80) size = $urandom_range(1, 8);
        else if (r < 95) size = $urandom_range(9, 20);
        else size = $urandom_range(21, Capacity);
      end
      r = $urandom_range(0, 99);
      spread = (r < 60) ? SpreadWide : (r < 85) ? SpreadNarrow : SpreadEdge;

      // receiver holds off while this set and the next are offered
      if (set_idx == 3) hold_reqs++;
      // sender waits for the block to empty
      if (set_idx == 5) drain_results();
      // stretch with no idling on either side
      no_idle = (set_idx >= 6 && set_idx <= 9);

      for (i = 0; i < size; i++) set_q.push_back(pick_value(spread));
      send_queued_set();
      set_idx++;
    end
    no_idle = 1'b0;

    drain_results();
    repeat (DrainCycles) @(negedge clk);
    if (errors == 0) begin
      $display("hybrid_merge_sort test passed");
    end else begin
      $display("hybrid_merge_sort test failed");
    end
    $finish;
  end

endmodule
